FILE: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define SKD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("skd assertion failed");

// next-cycle implication, disabled while reset is held
`define SKD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("skd assertion failed");

`endif

FILE: rtl/core/skd_pkg.sv
// shared constants, types and helper functions of the kd oscillator core
package skd_pkg;

    localparam int WINDOW        = 9;
    localparam int PRICE_BITS    = 24;
    localparam int VAL_BITS      = 14;
    localparam int NUM_BITS      = PRICE_BITS + VAL_BITS;
    localparam int SUM_BITS      = VAL_BITS + 1;
    localparam int SCAN_BITS     = $clog2(WINDOW);
    localparam int DIV_CNT_BITS  = $clog2(VAL_BITS);
    localparam int DIV3_SHIFT    = 17;
    localparam int PROD_BITS     = SUM_BITS + DIV3_SHIFT;

    localparam logic [VAL_BITS-1:0]  FULL_SCALE    = VAL_BITS'(10000);
    localparam logic [VAL_BITS-1:0]  RESET_INITIAL = VAL_BITS'(5000);
    localparam logic [PROD_BITS-1:0] DIV3_MUL      = PROD_BITS'(43691);

    typedef logic [PRICE_BITS-1:0] t_price;
    typedef logic [VAL_BITS-1:0]   t_val;

    // one stored bar of the window
    typedef struct packed {
        t_price hi;
        t_price lo;
        logic   valid;
    } t_bar;

    // running extremes handed along the chain
    typedef struct packed {
        t_price hi;
        t_price lo;
    } t_run;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_KCALC,
        ST_DCALC,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_FULL,
        SEL_QUOT
    } t_rsv_sel;

    // floor(x/3) by reciprocal multiply, exact for x below 2**17
    function automatic t_val div3(input logic [SUM_BITS-1:0] x);
        logic [PROD_BITS-1:0] p;
        p = PROD_BITS'(x) * DIV3_MUL;
        return t_val'(p >> DIV3_SHIFT);
    endfunction

    // starting k and d, saturated at full scale
    function automatic t_val start_value(input t_val init);
        return (init > FULL_SCALE) ? FULL_SCALE : init;
    endfunction

endpackage

FILE: rtl/core/skd_stream_if.sv
// valid/ready stream interfaces for price bars and oscillator results
interface skd_in_if;
    logic                          valid;
    logic                          ready;
    logic [skd_pkg::PRICE_BITS-1:0] high_price;
    logic [skd_pkg::PRICE_BITS-1:0] low_price;
    logic [skd_pkg::PRICE_BITS-1:0] close_price;
    logic                          restart;

    modport source (output valid, high_price, low_price, close_price, restart, input ready);
    modport sink   (input valid, high_price, low_price, close_price, restart, output ready);
endinterface

interface skd_out_if;
    logic                         valid;
    logic                         ready;
    logic [skd_pkg::VAL_BITS-1:0] rsv_value;
    logic [skd_pkg::VAL_BITS-1:0] k_value;
    logic [skd_pkg::VAL_BITS-1:0] d_value;
    logic                         flat_range;

    modport source (output valid, rsv_value, k_value, d_value, flat_range, input ready);
    modport sink   (input valid, rsv_value, k_value, d_value, flat_range, output ready);
endinterface

FILE: rtl/core/skd_cell.sv
// one window cell: holds a bar, shifts it on, folds it into the running extremes
module skd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_shift,
    input  logic          i_clear,
    input  skd_pkg::t_bar i_prev,
    input  skd_pkg::t_run i_run,
    output skd_pkg::t_bar o_bar,
    output skd_pkg::t_run o_run
);

    skd_pkg::t_price r_hi;
    skd_pkg::t_price r_lo;
    logic            r_valid;
    skd_pkg::t_run   r_run;
    skd_pkg::t_run   n_run;

    // bar storage, valid cleared on reset and on a restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_clear ? 1'b0 : i_prev.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_hi <= i_prev.hi;
            r_lo <= i_prev.lo;
        end
    end

    // fold own bar into the extremes from the previous cell
    always_comb begin
        n_run = i_run;
        if (r_valid) begin
            if (r_hi > i_run.hi) begin
                n_run.hi = r_hi;
            end
            if (r_lo < i_run.lo) begin
                n_run.lo = r_lo;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

    assign o_bar = '{hi: r_hi, lo: r_lo, valid: r_valid};
    assign o_run = r_run;

endmodule

FILE: rtl/core/skd_divider.sv
// restoring divider, one quotient bit per cycle, quotient known to fit VAL_BITS
module skd_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [skd_pkg::NUM_BITS-1:0]  i_num,
    input  skd_pkg::t_price               i_den,
    output logic                          o_done,
    output skd_pkg::t_val                 o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [skd_pkg::DIV_CNT_BITS-1:0]  r_cnt;
    skd_pkg::t_price                   r_rem;
    skd_pkg::t_price                   r_den;
    skd_pkg::t_val                     r_lo;
    skd_pkg::t_val                     r_quot;
    logic [skd_pkg::PRICE_BITS:0]      w_trial;
    logic                              w_fit;

    // bring down the next numerator bit and try the subtract
    assign w_trial = {r_rem, r_lo[skd_pkg::VAL_BITS-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == skd_pkg::DIV_CNT_BITS'(skd_pkg::VAL_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: the high part of the numerator is already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num[skd_pkg::NUM_BITS-1:skd_pkg::VAL_BITS];
            r_lo   <= i_num[skd_pkg::VAL_BITS-1:0];
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_fit ? skd_pkg::PRICE_BITS'(w_trial - {1'b0, r_den})
                            : w_trial[skd_pkg::PRICE_BITS-1:0];
            r_lo   <= {r_lo[skd_pkg::VAL_BITS-2:0], 1'b0};
            r_quot <= {r_quot[skd_pkg::VAL_BITS-2:0], w_fit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

FILE: rtl/core/stochastic_kd_oscillator_core.sv
// top level of the kd stochastic oscillator core
// A bar whose RSV needs the divider goes, after acceptance, through the scan, while the
// running highest and lowest ripple one cell per cycle down the window chain, then the
// prepare and multiply states, the one-bit-per-cycle divider for RSV, and the K, D and
// output register steps. When RSV is forced to 0 (flat range or close at or below the
// lowest) or to full scale (close at or above the highest) the divider is skipped. Ready
// is high only between bars, from the cycle after a result is loaded, so a bar is accepted
// only once the one before it has been fully processed. A finished result sits in the
// output register, so the next bar is accepted while it waits to be taken; that bar's own
// result is held back until the register is free. restart clears the window down to the
// restarting bar and reloads K and D from the configured initial value (i_cfg_data),
// which is saturated to 10000 and only takes effect at restart.
module stochastic_kd_oscillator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  skd_pkg::t_val         i_cfg_data,
    skd_in_if.sink                i_bar,
    skd_out_if.source             o_res
);

    skd_pkg::t_state   r_state;
    skd_pkg::t_state   n_state;
    logic [skd_pkg::SCAN_BITS-1:0] r_scan;
    skd_pkg::t_val     r_init;
    skd_pkg::t_val     r_k;
    skd_pkg::t_val     r_d;
    skd_pkg::t_val     r_rsv;
    skd_pkg::t_price   r_close;
    skd_pkg::t_price   r_diff;
    skd_pkg::t_price   r_den;
    logic              r_flat;
    skd_pkg::t_rsv_sel r_sel;

    logic              r_o_valid;
    skd_pkg::t_val     r_o_rsv;
    skd_pkg::t_val     r_o_k;
    skd_pkg::t_val     r_o_d;
    logic              r_o_flat;

    logic              w_accept;
    logic              w_load_out;
    logic              w_div_start;
    logic              w_div_done;
    skd_pkg::t_val     w_quot;
    skd_pkg::t_val     w_rsv;
    logic [skd_pkg::NUM_BITS-1:0] w_num;
    skd_pkg::t_run     w_final;

    skd_pkg::t_bar     w_bar [skd_pkg::WINDOW+1];
    skd_pkg::t_run     w_run [skd_pkg::WINDOW+1];

    assign w_accept = i_bar.valid && i_bar.ready;

    // window chain: newest bar enters cell zero
    assign w_bar[0] = '{hi: i_bar.high_price, lo: i_bar.low_price, valid: 1'b1};
    assign w_run[0] = '{hi: '0, lo: '1};

    for (genvar g = 0; g < skd_pkg::WINDOW; g++) begin : g_cell
        skd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_clear ((g == 0) ? 1'b0 : i_bar.restart),
            .i_prev  (w_bar[g]),
            .i_run   (w_run[g]),
            .o_bar   (w_bar[g+1]),
            .o_run   (w_run[g+1])
        );
    end

    assign w_final = w_run[skd_pkg::WINDOW];

    // scaled numerator feeds the divider register directly
    assign w_num = skd_pkg::NUM_BITS'(r_diff) * skd_pkg::NUM_BITS'(skd_pkg::FULL_SCALE);

    skd_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // rsv selection: special-case values or the divider quotient
    always_comb begin
        unique case (r_sel)
            skd_pkg::SEL_ZERO: w_rsv = '0;
            skd_pkg::SEL_FULL: w_rsv = skd_pkg::FULL_SCALE;
            skd_pkg::SEL_QUOT: w_rsv = w_quot;
            default:           w_rsv = '0;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and handshake outputs
    always_comb begin
        n_state     = r_state;
        i_bar.ready = 1'b0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            skd_pkg::ST_IDLE: begin
                i_bar.ready = 1'b1;
                if (i_bar.valid) begin
                    n_state = skd_pkg::ST_SCAN;
                end
            end
            skd_pkg::ST_SCAN: begin
                if (r_scan == skd_pkg::SCAN_BITS'(skd_pkg::WINDOW - 1)) begin
                    n_state = skd_pkg::ST_PREP;
                end
            end
            skd_pkg::ST_PREP: begin
                n_state = skd_pkg::ST_MUL;
            end
            skd_pkg::ST_MUL: begin
                if (r_sel == skd_pkg::SEL_QUOT) begin
                    w_div_start = 1'b1;
                    n_state     = skd_pkg::ST_DIV;
                end else begin
                    n_state = skd_pkg::ST_KCALC;
                end
            end
            skd_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = skd_pkg::ST_KCALC;
                end
            end
            skd_pkg::ST_KCALC: begin
                n_state = skd_pkg::ST_DCALC;
            end
            skd_pkg::ST_DCALC: begin
                n_state = skd_pkg::ST_DONE;
            end
            skd_pkg::ST_DONE: begin
                if (!r_o_valid || o_res.ready) begin
                    w_load_out = 1'b1;
                    n_state    = skd_pkg::ST_IDLE;
                end
            end
            default: n_state = skd_pkg::ST_IDLE;
        endcase
    end

    // configuration register and smoothing lines
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init <= skd_pkg::RESET_INITIAL;
            r_k    <= skd_pkg::start_value(skd_pkg::RESET_INITIAL);
            r_d    <= skd_pkg::start_value(skd_pkg::RESET_INITIAL);
        end else begin
            if (i_cfg_we) begin
                r_init <= i_cfg_data;
            end
            if (w_accept && i_bar.restart) begin
                r_k <= skd_pkg::start_value(r_init);
                r_d <= skd_pkg::start_value(r_init);
            end else if (r_state == skd_pkg::ST_KCALC) begin
                r_k <= skd_pkg::div3({r_k, 1'b0} + skd_pkg::SUM_BITS'(w_rsv));
            end else if (r_state == skd_pkg::ST_DCALC) begin
                r_d <= skd_pkg::div3({r_d, 1'b0} + skd_pkg::SUM_BITS'(r_k));
            end
        end
    end

    // scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= '0;
        end else if (w_accept) begin
            r_scan <= '0;
        end else if (r_state == skd_pkg::ST_SCAN) begin
            r_scan <= r_scan + 1'b1;
        end
    end

    // per-bar datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_close <= i_bar.close_price;
        end
        if (r_state == skd_pkg::ST_PREP) begin
            r_flat <= (w_final.hi <= w_final.lo);
            r_diff <= r_close - w_final.lo;
            r_den  <= w_final.hi - w_final.lo;
            if ((w_final.hi <= w_final.lo) || (r_close <= w_final.lo)) begin
                r_sel <= skd_pkg::SEL_ZERO;
            end else if (r_close >= w_final.hi) begin
                r_sel <= skd_pkg::SEL_FULL;
            end else begin
                r_sel <= skd_pkg::SEL_QUOT;
            end
        end
        if (r_state == skd_pkg::ST_KCALC) begin
            r_rsv <= w_rsv;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load_out) begin
            r_o_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_rsv  <= r_rsv;
            r_o_k    <= r_k;
            r_o_d    <= r_d;
            r_o_flat <= r_flat;
        end
    end

    assign o_res.valid      = r_o_valid;
    assign o_res.rsv_value  = r_o_rsv;
    assign o_res.k_value    = r_o_k;
    assign o_res.d_value    = r_o_d;
    assign o_res.flat_range = r_o_flat;

endmodule

FILE: rtl/core/skd_checker.sv
// port-level assertions for the kd oscillator core and their bind
`include "assert_macros.svh"

module skd_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  logic [skd_pkg::VAL_BITS-1:0] i_rsv,
    input  logic [skd_pkg::VAL_BITS-1:0] i_k,
    input  logic [skd_pkg::VAL_BITS-1:0] i_d,
    input  logic                 i_flat
);

    // a stalled result stays offered
    `SKD_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // one bar at a time: no back-to-back acceptance
    `SKD_ASSERT_NXT(a_one_bar, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // flat window always reports zero rsv
    `SKD_ASSERT_IMP(a_flat_zero, i_clk, i_rst_n, i_out_valid && i_flat, i_rsv == '0)

    // all lines stay within full scale
    `SKD_ASSERT_IMP(a_range, i_clk, i_rst_n, i_out_valid,
        (i_rsv <= skd_pkg::FULL_SCALE) && (i_k <= skd_pkg::FULL_SCALE) && (i_d <= skd_pkg::FULL_SCALE))

endmodule

bind stochastic_kd_oscillator_core skd_checker u_skd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_bar.valid),
    .i_in_ready  (i_bar.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_rsv       (o_res.rsv_value),
    .i_k         (o_res.k_value),
    .i_d         (o_res.d_value),
    .i_flat      (o_res.flat_range)
);
